[hw/rtl/assert_macros.svh]
// Assertion macros shared by the driver RTL.
// Expects signals named clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge, off while reset is asserted.
`define BSSD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define BSSD_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/bssd_pkg.sv]
// Package for the serial seven-segment driver: constants, types, segment table.
// No dependencies; used by every module of the driver.
`default_nettype none

package bssd_pkg;

	localparam int NUM_DIGITS_DEF = 4;
	localparam int BYTE_BITS      = 8;
	localparam int VALUE_W        = 32;
	localparam int DIGIT_W        = 4;
	localparam int FRAME_W        = 2 * BYTE_BITS;
	localparam int BIT_CNT_W      = $clog2(FRAME_W);
	localparam int CONV_CNT_W     = $clog2(VALUE_W);
	localparam int TDATA_OUT_W    = 8;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_DONE
	} fr_state_t;

	typedef enum logic {
		BK_IDLE,
		BK_SHIFT
	} bk_state_t;

	// One serial beat toward the shift register.
	typedef struct packed {
		logic serial_bit;
		logic latch_after;
		logic last_bit;
	} out_beat_t;

	// Occupancy status of the digit queue.
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Active-low segment pattern; codes above nine show as zero.
	function automatic logic [BYTE_BITS-1:0] seg_pattern(input logic [DIGIT_W-1:0] digit);
		logic [BYTE_BITS-1:0] pat;
		unique case (digit)
			4'd0:    pat = 8'd192;
			4'd1:    pat = 8'd249;
			4'd2:    pat = 8'd164;
			4'd3:    pat = 8'd176;
			4'd4:    pat = 8'd153;
			4'd5:    pat = 8'd146;
			4'd6:    pat = 8'd130;
			4'd7:    pat = 8'd248;
			4'd8:    pat = 8'd128;
			4'd9:    pat = 8'd144;
			default: pat = 8'd192;
		endcase
		return pat;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/bssd_front.sv]
// Front end: accepts a binary value and converts it to decimal digits.
// Uses bssd_pkg; feeds bssd_queue.
`default_nettype none

module bssd_front import bssd_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [VALUE_W-1:0]            s_tdata,
	output logic                               dig_valid,
	input  wire logic                          dig_ready,
	output logic [NUM_DIGITS*DIGIT_W-1:0]      dig_data
);

	localparam int DW = NUM_DIGITS * DIGIT_W;

	fr_state_t                                 state_q, state_d;
	logic [VALUE_W-1:0]                        value_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]        bcd_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0]        adj;
	logic [DW-1:0]                             shifted;
	logic [CONV_CNT_W-1:0]                     cnt_q;

	// One shift-and-add-three step; digits above the kept ones fall off the top,
	// which leaves the value modulo a power of ten.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		shifted = DW'({adj, value_q[VALUE_W-1]});
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (s_tvalid) state_d = FR_CONV;
			FR_CONV: if (cnt_q == CONV_CNT_W'(VALUE_W - 1)) state_d = FR_DONE;
			FR_DONE: if (dig_ready) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == FR_IDLE);
		dig_valid = (state_q == FR_DONE);
		dig_data  = bcd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == FR_IDLE) begin
				cnt_q <= '0;
			end else if (state_q == FR_CONV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			value_q <= s_tdata;
			bcd_q   <= '0;
		end else if (state_q == FR_CONV) begin
			value_q <= {value_q[VALUE_W-2:0], 1'b0};
			bcd_q   <= shifted;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bssd_queue.sv]
// Two-entry queue of converted digit sets between front and back end.
// Uses bssd_pkg for its status struct.
`default_nettype none

module bssd_queue import bssd_pkg::*; #(
	parameter int DW = NUM_DIGITS_DEF * DIGIT_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire logic [DW-1:0] wr_data,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output logic [DW-1:0]      rd_data,
	output q_stat_t            stat
);

	logic [DW-1:0] mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign wr_ready   = (count_q != 2'd2);
	assign rd_valid   = (count_q != 2'd0);
	assign rd_data    = mem_q[rd_ptr_q];
	assign push       = wr_valid && wr_ready;
	assign pop        = rd_valid && rd_ready;
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

`default_nettype wire

[hw/rtl/bssd_back.sv]
// Back end: serializes digit frames (segment byte, select byte) one bit a beat.
// Uses bssd_pkg; reads from bssd_queue.
`default_nettype none

module bssd_back import bssd_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	output logic                                   q_ready,
	input  wire logic [NUM_DIGITS*DIGIT_W-1:0]     q_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output out_beat_t                              out_beat
);

	localparam int PW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

	bk_state_t                          state_q, state_d;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [PW-1:0]                      pos_q;
	logic [BIT_CNT_W-1:0]               bit_q;
	logic                               out_valid_q;
	out_beat_t                          out_beat_q;
	logic                               can_load;
	logic                               advance;
	logic                               frame_end;
	logic                               seq_end;
	logic [FRAME_W-1:0]                 frame;
	logic [PW-1:0]                      dig_idx;

	assign can_load = !out_valid_q || out_ready;
	assign dig_idx  = PW'(NUM_DIGITS - 1) - pos_q;

	always_comb begin
		frame     = {seg_pattern(digits_q[dig_idx]), BYTE_BITS'(1) << pos_q};
		frame_end = (bit_q == BIT_CNT_W'(FRAME_W - 1));
		seq_end   = frame_end && (pos_q == PW'(NUM_DIGITS - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid) state_d = BK_SHIFT;
			BK_SHIFT: if (advance && seq_end && !q_valid) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		advance = (state_q == BK_SHIFT) && can_load;
		q_ready = (state_q == BK_IDLE) || (advance && seq_end);
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			pos_q       <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_valid && q_ready) begin
				pos_q <= '0;
				bit_q <= '0;
			end else if (advance) begin
				bit_q <= bit_q + 1'b1;
				if (frame_end) pos_q <= pos_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) digits_q <= q_data;
		if (advance) begin
			out_beat_q.serial_bit  <= frame[BIT_CNT_W'(FRAME_W - 1) - bit_q];
			out_beat_q.latch_after <= frame_end;
			out_beat_q.last_bit    <= seq_end;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bcd_seven_segment_serial_driver_core.sv]
// Top level of the serial seven-segment driver: front end, digit queue, back end.
// Depends on bssd_pkg, bssd_front, bssd_queue, bssd_back and assert_macros.svh.
//
//   Channel | Direction | Handshake          | Payload
//   s_*     | in        | s_tvalid/s_tready  | s_tdata[31:0] = value
//   m_*     | out       | m_tvalid/m_tready  | m_tdata[0] = serial_bit, m_tuser[0] =
//           |           |                    | latch_after, m_tlast = last_bit
//
// Each value yields NUM_DIGITS * 16 beats (64 by default), one per cycle while m_tready
// is high; the bit serializer sets the sustained rate.
// Decimal conversion in the front end (32 shift-and-add-three steps in one shared unit,
// then hand-off) overlaps the serializing of the previous value.
// The first beat of a value taken into an idle block follows its conversion and the queue.
// Reset is asynchronous and clears all control state at once; no clearing pass follows.
// A stalled output holds the back end; the two-entry queue lets the front run until full.
`default_nettype none
`include "assert_macros.svh"

module bcd_seven_segment_serial_driver_core import bssd_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input value stream.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [VALUE_W-1:0]     s_tdata,   // [31:0] value
	// Serial bit stream toward the shift-register display.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [TDATA_OUT_W-1:0]      m_tdata,   // [0] serial_bit, [7:1] zero
	output logic                        m_tuser,   // [0] latch_after
	output logic                        m_tlast    // last bit of the 64-beat sequence
);

	localparam int DW = NUM_DIGITS * DIGIT_W;

	// Front end to queue.
	logic          fq_valid;
	logic          fq_ready;
	logic [DW-1:0] fq_data;

	// Queue to back end.
	logic          qb_valid;
	logic          qb_ready;
	logic [DW-1:0] qb_data;

	q_stat_t       q_stat;
	out_beat_t     beat;

	// The front end converts one value at a time by double dabble over all 32 input bits.
	bssd_front #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.dig_valid (fq_valid),
		.dig_ready (fq_ready),
		.dig_data  (fq_data)
	);

	// The queue decouples conversion from the much longer serial output of each value.
	bssd_queue #(
		.DW(DW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data),
		.stat     (q_stat)
	);

	// The back end walks digit positions and frame bits and owns the output register.
	bssd_back #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_data    (qb_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_beat  (beat)
	);

	assign m_tdata = {(TDATA_OUT_W - 1)'(0), beat.serial_bit};
	assign m_tuser = beat.latch_after;
	assign m_tlast = beat.last_bit;

	// The sequence end always closes a digit frame.
	`BSSD_ASSERT(a_last_is_latch, (m_tvalid && m_tlast) |-> m_tuser, "last beat without latch mark")
	// The queue occupancy flags must be mutually exclusive.
	`BSSD_NEVER(a_q_flags, q_stat.full && q_stat.empty, "queue full and empty at once")
	// A held output beat must not change while the sink stalls.
	`BSSD_ASSERT(a_beat_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(beat)), "beat changed under stall")

endmodule

`default_nettype wire
